@@ src/apm_pkg.sv @@
// Shared types and constants for the absolute pointer report mapper.
// No dependencies; every other file in src refers to it by scoped names.
`default_nettype none

package apm_pkg;

  // Default coordinate width in bits.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Width of the configuration register index.
  localparam int unsigned CFG_ADDR_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_LOGICAL_MAX_X = 3'd2,
    REG_LOGICAL_MAX_Y = 3'd3,
    REG_OFFSET_X      = 3'd4,
    REG_OFFSET_Y      = 3'd5
  } apm_reg_t;

  // Bit positions in the report state field.
  localparam int unsigned STATE_TIP_BIT   = 0;
  localparam int unsigned STATE_RANGE_BIT = 1;
  localparam int unsigned STATE_W         = 2;

  // Sideband that travels beside the lanes: whether a report is due, and its
  // contact state bits.
  typedef struct packed {
    logic                 valid;
    logic [STATE_W-1:0]   state;
  } apm_side_t;

endpackage : apm_pkg

`default_nettype wire

@@ src/absolute_pointer_report_mapper.sv @@
// Top level of the absolute pointer report mapper: configuration registers,
// the x and y lanes and the merging stage. Depends on apm_pkg, apm_lane,
// apm_div and apm_merge.
//
//   Channel   Ports                               Transfer rule
//   -------   ---------------------------------   --------------------------
//   event     start, busy, in_*                   start high and busy low
//   report    out_strobe, out_report_*            out_strobe high, one cycle
//   config    cfg_valid, cfg_ready, cfg_addr,     cfg_valid and cfg_ready
//             cfg_wdata
//
// From its transfer to its report strobe, each event's coordinates pass the
// one-bit-per-stage divider in each lane, plus a clamp, a multiply and an
// output stage. The pipeline takes a new event every cycle, so busy is low.
// Reset (rst_n low, synchronous) clears all configuration registers and
// every in-flight event. The receiver cannot stall: a report is on the
// out_ ports for exactly one cycle. Events with link_up low give no report.
`default_nettype none

module absolute_pointer_report_mapper #(
  parameter int unsigned COORD_BITS = apm_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  // Event channel.
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_operation,
  input  wire logic [COORD_BITS-1:0]             in_coord_x,
  input  wire logic [COORD_BITS-1:0]             in_coord_y,
  input  wire logic                              in_tip_switch,
  input  wire logic                              in_in_range,
  input  wire logic                              in_link_up,

  // Report channel.
  output logic                                   out_strobe,
  output logic [apm_pkg::STATE_W-1:0]            out_report_state,
  output logic [COORD_BITS-1:0]                  out_report_x,
  output logic [COORD_BITS-1:0]                  out_report_y,

  // Configuration channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [apm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [COORD_BITS-1:0]             cfg_wdata
);

  localparam int unsigned DEPTH   = COORD_BITS + 2;
  localparam int unsigned LATENCY = DEPTH + 1;

  // Configuration registers. The user must change them only while no event
  // is in flight; the block does not enforce it. Lanes read them directly.
  logic [COORD_BITS-1:0] screen_w_r, screen_w_nxt;
  logic [COORD_BITS-1:0] screen_h_r, screen_h_nxt;
  logic [COORD_BITS-1:0] lmax_x_r,   lmax_x_nxt;
  logic [COORD_BITS-1:0] lmax_y_r,   lmax_y_nxt;
  logic [COORD_BITS-1:0] off_x_r,    off_x_nxt;
  logic [COORD_BITS-1:0] off_y_r,    off_y_nxt;

  logic                  accept;
  logic                  cfg_write;
  logic                  scale_en;
  apm_pkg::apm_side_t    side;
  logic [COORD_BITS-1:0] lane_x;
  logic [COORD_BITS-1:0] lane_y;

  // The pipeline never refuses an event or a configuration write.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // Register writes decode the index; indexes past the list are ignored.
  always_comb begin
    screen_w_nxt = screen_w_r;
    screen_h_nxt = screen_h_r;
    lmax_x_nxt   = lmax_x_r;
    lmax_y_nxt   = lmax_y_r;
    off_x_nxt    = off_x_r;
    off_y_nxt    = off_y_r;
    if (cfg_write) begin
      case (cfg_addr)
        apm_pkg::REG_SCREEN_WIDTH:  screen_w_nxt = cfg_wdata;
        apm_pkg::REG_SCREEN_HEIGHT: screen_h_nxt = cfg_wdata;
        apm_pkg::REG_LOGICAL_MAX_X: lmax_x_nxt   = cfg_wdata;
        apm_pkg::REG_LOGICAL_MAX_Y: lmax_y_nxt   = cfg_wdata;
        apm_pkg::REG_OFFSET_X:      off_x_nxt    = cfg_wdata;
        apm_pkg::REG_OFFSET_Y:      off_y_nxt    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= '0;
      screen_h_r <= '0;
      lmax_x_r   <= '0;
      lmax_y_r   <= '0;
      off_x_r    <= '0;
      off_y_r    <= '0;
    end else begin
      screen_w_r <= screen_w_nxt;
      screen_h_r <= screen_h_nxt;
      lmax_x_r   <= lmax_x_nxt;
      lmax_y_r   <= lmax_y_nxt;
      off_x_r    <= off_x_nxt;
      off_y_r    <= off_y_nxt;
    end
  end

  // Pixel scaling needs both screen dimensions; each lane further checks
  // its own divisor and logical max.
  assign scale_en = in_operation && (screen_w_r != '0) && (screen_h_r != '0);

  // A report is due only for a transferred event while the link is up.
  always_comb begin
    side.valid                        = accept && in_link_up;
    side.state[apm_pkg::STATE_TIP_BIT]   = in_tip_switch;
    side.state[apm_pkg::STATE_RANGE_BIT] = in_in_range;
  end

  apm_lane #(
    .COORD_BITS (COORD_BITS)
  ) u_lane_x (
    .clk      (clk),
    .scale_en (scale_en),
    .coord    (in_coord_x),
    .size     (screen_w_r),
    .lmax     (lmax_x_r),
    .offset   (off_x_r),
    .result   (lane_x)
  );

  apm_lane #(
    .COORD_BITS (COORD_BITS)
  ) u_lane_y (
    .clk      (clk),
    .scale_en (scale_en),
    .coord    (in_coord_y),
    .size     (screen_h_r),
    .lmax     (lmax_y_r),
    .offset   (off_y_r),
    .result   (lane_y)
  );

  apm_merge #(
    .COORD_BITS (COORD_BITS),
    .DEPTH      (DEPTH)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .side_in (side),
    .x_in    (lane_x),
    .y_in    (lane_y),
    .strobe  (out_strobe),
    .state   (out_report_state),
    .x_out   (out_report_x),
    .y_out   (out_report_y)
  );

  // A report strobe always traces back to an event with the link up.
  a_strobe_origin : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept && in_link_up, LATENCY))
    else $error("report strobe without a matching event");

  // The contact state bits travel with their event.
  a_state_align : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_report_state ==
                    $past({in_in_range, in_tip_switch}, LATENCY)))
    else $error("report state does not match its event");

  // With a nonzero logical max the coordinates never exceed it.
  a_clamp_xy : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((lmax_x_r == '0 || out_report_x <= lmax_x_r) &&
                    (lmax_y_r == '0 || out_report_y <= lmax_y_r)))
    else $error("report coordinate above logical max");

endmodule : absolute_pointer_report_mapper

`default_nettype wire

@@ src/apm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Takes its default width from apm_pkg; instantiated by apm_lane.
`default_nettype none

module apm_div #(
  parameter int unsigned COORD_BITS = apm_pkg::COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic [2*COORD_BITS-1:0]   dividend,
  input  wire logic [COORD_BITS-1:0]     divisor,
  output logic      [COORD_BITS-1:0]     quotient
);

  localparam int unsigned CB = COORD_BITS;

  // The caller guarantees dividend < divisor * 2^CB, so the upper half is
  // already a valid partial remainder and the quotient fits in CB bits.
  logic [CB-1:0] rem_r  [CB];
  logic [CB-1:0] lo_r   [CB];
  logic [CB-1:0] quo_r  [CB];
  logic [CB-1:0] dvs_r  [CB];
  logic [CB-1:0] rem_nxt [CB];
  logic [CB-1:0] lo_nxt  [CB];
  logic [CB-1:0] quo_nxt [CB];

  for (genvar s = 0; s < CB; s++) begin : g_stage
    logic [CB-1:0] rem_in;
    logic [CB-1:0] lo_in;
    logic [CB-1:0] quo_in;
    logic [CB-1:0] dvs_in;
    logic [CB:0]   trial;
    logic [CB:0]   diff;
    logic          fits;

    if (s == 0) begin : g_first
      assign rem_in = dividend[2*CB-1:CB];
      assign lo_in  = dividend[CB-1:0];
      assign quo_in = '0;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign lo_in  = lo_r[s-1];
      assign quo_in = quo_r[s-1];
      assign dvs_in = dvs_r[s-1];
    end

    assign trial = {rem_in, lo_in[CB-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign fits  = (trial >= {1'b0, dvs_in});

    always_comb begin
      rem_nxt[s] = fits ? diff[CB-1:0] : trial[CB-1:0];
      lo_nxt[s]  = {lo_in[CB-2:0], 1'b0};
      quo_nxt[s] = {quo_in[CB-2:0], fits};
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt[s];
      lo_r[s]  <= lo_nxt[s];
      quo_r[s] <= quo_nxt[s];
      dvs_r[s] <= dvs_in;
    end
  end

  assign quotient = quo_r[CB-1];

endmodule : apm_div

`default_nettype wire

@@ src/apm_lane.sv @@
// One coordinate lane: clamp, multiply, divide, then offset and clamp.
// Depends on apm_pkg for defaults and instantiates apm_div.
`default_nettype none

module apm_lane #(
  parameter int unsigned COORD_BITS = apm_pkg::COORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   scale_en,
  input  wire logic [COORD_BITS-1:0]  coord,
  input  wire logic [COORD_BITS-1:0]  size,
  input  wire logic [COORD_BITS-1:0]  lmax,
  input  wire logic [COORD_BITS-1:0]  offset,
  output logic      [COORD_BITS-1:0]  result
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SW = COORD_BITS + 2;

  logic [CB-1:0]   span;
  logic            scale;
  logic [CB-1:0]   mul_a_r, mul_a_nxt;
  logic [CB-1:0]   mul_b_r, mul_b_nxt;
  logic [CB-1:0]   dvs_r, dvs_nxt;
  logic [2*CB-1:0] prod_r, prod_nxt;
  logic [CB-1:0]   dvs1_r;
  logic [CB-1:0]   quo;
  logic [SW-1:0]   sum;
  logic            below;
  logic            above;

  assign span  = size - {{(CB-1){1'b0}}, 1'b1};
  assign scale = scale_en && (span != '0) && (lmax != '0);

  // Without scaling the value is divided by one, so it passes unchanged.
  always_comb begin
    if (scale) begin
      mul_a_nxt = (coord > span) ? span : coord;
      mul_b_nxt = lmax;
      dvs_nxt   = span;
    end else begin
      mul_a_nxt = coord;
      mul_b_nxt = {{(CB-1){1'b0}}, 1'b1};
      dvs_nxt   = {{(CB-1){1'b0}}, 1'b1};
    end
  end

  assign prod_nxt = {{CB{1'b0}}, mul_a_r} * {{CB{1'b0}}, mul_b_r};

  always_ff @(posedge clk) begin
    mul_a_r <= mul_a_nxt;
    mul_b_r <= mul_b_nxt;
    dvs_r   <= dvs_nxt;
    prod_r  <= prod_nxt;
    dvs1_r  <= dvs_r;
  end

  apm_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk      (clk),
    .dividend (prod_r),
    .divisor  (dvs1_r),
    .quotient (quo)
  );

  // Signed offset add, then clamp unless the logical max is zero.
  assign sum   = {2'b00, quo} + {{2{offset[CB-1]}}, offset};
  assign below = sum[SW-1];
  assign above = (sum > {2'b00, lmax});

  always_comb begin
    if (lmax == '0) begin
      result = sum[CB-1:0];
    end else if (below) begin
      result = '0;
    end else if (above) begin
      result = lmax;
    end else begin
      result = sum[CB-1:0];
    end
  end

endmodule : apm_lane

`default_nettype wire

@@ src/apm_merge.sv @@
// Merging stage: delays the report sideband to match the lanes and
// registers the complete report. Depends on apm_pkg for the sideband type.
`default_nettype none

module apm_merge #(
  parameter int unsigned COORD_BITS = apm_pkg::COORD_BITS_DEF,
  parameter int unsigned DEPTH      = COORD_BITS + 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire apm_pkg::apm_side_t                side_in,
  input  wire logic [COORD_BITS-1:0]             x_in,
  input  wire logic [COORD_BITS-1:0]             y_in,
  output logic                                   strobe,
  output logic [apm_pkg::STATE_W-1:0]            state,
  output logic [COORD_BITS-1:0]                  x_out,
  output logic [COORD_BITS-1:0]                  y_out
);

  apm_pkg::apm_side_t side_r [DEPTH];

  logic                          strobe_r, strobe_nxt;
  logic [apm_pkg::STATE_W-1:0]   state_r;
  logic [COORD_BITS-1:0]         x_r;
  logic [COORD_BITS-1:0]         y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        side_r[i] <= '0;
      end
    end else begin
      side_r[0] <= side_in;
      for (int i = 1; i < DEPTH; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign strobe_nxt = side_r[DEPTH-1].valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= side_r[DEPTH-1].state;
    x_r     <= x_in;
    y_r     <= y_in;
  end

  assign strobe = strobe_r;
  assign state  = state_r;
  assign x_out  = x_r;
  assign y_out  = y_r;

endmodule : apm_merge

`default_nettype wire

@@ tb/sv/apm_report_checker.sv @@
// Report checker for the absolute pointer report mapper: mirrors the register
// writes, predicts the report of every accepted event with the link up and compares it.
// Depends on apm_pkg for register indexes, state bit positions and widths.
module apm_report_checker #(
  parameter int unsigned W = apm_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_operation,
  input  logic [W-1:0]                   in_coord_x,
  input  logic [W-1:0]                   in_coord_y,
  input  logic                           in_tip_switch,
  input  logic                           in_in_range,
  input  logic                           in_link_up,
  input  logic                           out_strobe,
  input  logic [apm_pkg::STATE_W-1:0]    out_report_state,
  input  logic [W-1:0]                   out_report_x,
  input  logic [W-1:0]                   out_report_y,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [apm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [W-1:0]                   cfg_wdata,
  input  logic                           run_done,
  output int                             reports_due,
  output int                             fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import apm_pkg::*;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [W-1:0]       x;
    logic [W-1:0]       y;
  } pointer_report_t;

  logic [W-1:0] screen_w, screen_h, max_x, max_y, off_x, off_y;
  pointer_report_t expected_reports[$];
  bit drain_checked;

  // Pixel to logical scaling of one axis; a zero span or a zero logical max
  // leaves the coordinate as it is.
  function automatic logic [W-1:0] scale_to_logical(logic [W-1:0] v, logic [W-1:0] size,
                                                    logic [W-1:0] lmax);
    logic [W-1:0]   span;
    logic [2*W-1:0] prod;
    logic [2*W-1:0] quot;
    span = size - 1'b1;
    if (span == '0 || lmax == '0) return v;
    if (v > span) v = span;
    prod = {{W{1'b0}}, v} * {{W{1'b0}}, lmax};
    quot = prod / {{W{1'b0}}, span};
    return quot[W-1:0];
  endfunction

  // Adds the signed offset, then clamps to 0..lmax, or wraps when lmax is zero.
  function automatic logic [W-1:0] calibrate(logic [W-1:0] v, logic [W-1:0] off,
                                             logic [W-1:0] lmax);
    logic signed [W+1:0] sum;
    sum = $signed({2'b00, v}) + $signed({{2{off[W-1]}}, off});
    if (lmax == '0) return sum[W-1:0];
    if (sum < 0) return '0;
    if (sum > $signed({2'b00, lmax})) return lmax;
    return sum[W-1:0];
  endfunction

  function automatic pointer_report_t map_event(logic pixel, logic [W-1:0] x, logic [W-1:0] y,
                                                logic tip, logic near);
    pointer_report_t rep;
    logic [W-1:0]    lx;
    logic [W-1:0]    ly;
    lx = x;
    ly = y;
    if (pixel && screen_w != '0 && screen_h != '0) begin
      lx = scale_to_logical(x, screen_w, max_x);
      ly = scale_to_logical(y, screen_h, max_y);
    end
    rep.state                  = '0;
    rep.state[STATE_TIP_BIT]   = tip;
    rep.state[STATE_RANGE_BIT] = near;
    rep.x                      = calibrate(lx, off_x, max_x);
    rep.y                      = calibrate(ly, off_y, max_y);
    return rep;
  endfunction

  task automatic log_failure(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    pointer_report_t want;
    if (!rst_n) begin
      screen_w = '0;
      screen_h = '0;
      max_x    = '0;
      max_y    = '0;
      off_x    = '0;
      off_y    = '0;
      expected_reports.delete();
    end else begin
      if (out_strobe) begin
        if (expected_reports.size() == 0) begin
          log_failure($sformatf("report with none due: state=%0h x=%0h y=%0h",
                                out_report_state, out_report_x, out_report_y));
        end else begin
          want = expected_reports.pop_front();
          if (out_report_state !== want.state)
            log_failure($sformatf("report_state got %0h expected %0h",
                                  out_report_state, want.state));
          if (out_report_x !== want.x)
            log_failure($sformatf("report_x got %0h expected %0h", out_report_x, want.x));
          if (out_report_y !== want.y)
            log_failure($sformatf("report_y got %0h expected %0h", out_report_y, want.y));
        end
      end
      // Events with the link down are dropped by the block.
      if (start && !busy && in_link_up)
        expected_reports.push_back(map_event(in_operation, in_coord_x, in_coord_y,
                                             in_tip_switch, in_in_range));
      if (cfg_valid && cfg_ready) begin
        case (apm_reg_t'(cfg_addr))
          REG_SCREEN_WIDTH:  screen_w = cfg_wdata;
          REG_SCREEN_HEIGHT: screen_h = cfg_wdata;
          REG_LOGICAL_MAX_X: max_x    = cfg_wdata;
          REG_LOGICAL_MAX_Y: max_y    = cfg_wdata;
          REG_OFFSET_X:      off_x    = cfg_wdata;
          REG_OFFSET_Y:      off_y    = cfg_wdata;
          default: ;
        endcase
      end
      if (run_done && !drain_checked) begin
        drain_checked = 1'b1;
        if (expected_reports.size() != 0)
          log_failure($sformatf("%0d reports never arrived", expected_reports.size()));
      end
    end
    reports_due <= expected_reports.size();
  end

endmodule

@@ tb/sv/tb_absolute_pointer_report_mapper.sv @@
// Top of the absolute pointer report mapper testbench: clock, reset, event and
// register stimulus, watchdog and verdict. Depends on apm_pkg, the block and
// apm_report_checker, which does all prediction and comparison.
module tb_absolute_pointer_report_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  import apm_pkg::*;

  localparam int unsigned CW = COORD_BITS_DEF;
  // Transfer to report strobe through the pipeline of the block.
  localparam int LATENCY = CW + 3;
  // Longest correct stretch without any transfer is a sender gap or the
  // pipeline draining plus the idle pause, well under this limit.
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_PHASES = 14;
  localparam int REPORTS_PER_PHASE = 87;

  typedef enum logic {
    OP_LOGICAL = 1'b0,
    OP_PIXEL   = 1'b1
  } pointer_op_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_operation;
  logic [CW-1:0]         in_coord_x;
  logic [CW-1:0]         in_coord_y;
  logic                  in_tip_switch;
  logic                  in_in_range;
  logic                  in_link_up;
  logic                  out_strobe;
  logic [STATE_W-1:0]    out_report_state;
  logic [CW-1:0]         out_report_x;
  logic [CW-1:0]         out_report_y;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CW-1:0]         cfg_wdata;
  logic                  run_done;
  int                    reports_due;
  int                    fail_count;
  int                    idle_cycles;

  absolute_pointer_report_mapper #(.COORD_BITS(CW)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_tip_switch    (in_tip_switch),
    .in_in_range      (in_in_range),
    .in_link_up       (in_link_up),
    .out_strobe       (out_strobe),
    .out_report_state (out_report_state),
    .out_report_x     (out_report_x),
    .out_report_y     (out_report_y),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  // The checker sees every channel exactly as the block does and hands back
  // how many reports are still due and how many failures it has logged.
  apm_report_checker #(.W(CW)) report_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_tip_switch    (in_tip_switch),
    .in_in_range      (in_in_range),
    .in_link_up       (in_link_up),
    .out_strobe       (out_strobe),
    .out_report_state (out_report_state),
    .out_report_x     (out_report_x),
    .out_report_y     (out_report_y),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .run_done         (run_done),
    .reports_due      (reports_due),
    .fail_count       (fail_count)
  );

  // A 20 ns clock. Stimulus changes on the falling edge, so the block and the
  // checker always see settled inputs at the rising edge.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The watchdog restarts its count on any transfer of any channel. If the
  // block stops taking events, writes or producing reports, the run ends here.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("** absolute_pointer_report_mapper: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one event and holds it until the block takes it. Start is left
  // high so that back-to-back events form a burst with no bubble.
  task automatic send_event(pointer_op_t op, logic [CW-1:0] x, logic [CW-1:0] y,
                            logic tip, logic near, logic link);
    @(negedge clk);
    start         <= 1'b1;
    in_operation  <= op;
    in_coord_x    <= x;
    in_coord_y    <= y;
    in_tip_switch <= tip;
    in_in_range   <= near;
    in_link_up    <= link;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // One register write transfer. Valid stays high for the next write and is
  // lowered by the caller once the whole set is written.
  task automatic write_reg(apm_reg_t idx, logic [CW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stops the sender and waits until every due report has been checked. A
  // dropped event gives no report but may still be in the pipeline, so the
  // pipeline depth is waited out on top of that.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (reports_due != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Registers are only rewritten with the block idle, and always all six.
  task automatic set_config(logic [CW-1:0] sw, logic [CW-1:0] sh, logic [CW-1:0] mx,
                            logic [CW-1:0] my, logic [CW-1:0] ox, logic [CW-1:0] oy);
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, sh);
    write_reg(REG_LOGICAL_MAX_X, mx);
    write_reg(REG_LOGICAL_MAX_Y, my);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sizes and logical maxima, with the disabling zero, the size of one that
  // makes the divisor vanish, and the all-ones value weighted in.
  function automatic logic [CW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CW'(1);
      2:       return '1;
      3:       return CW'(2);
      4:       return CW'($urandom);
      default: return CW'($urandom_range(3, 2048));
    endcase
  endfunction

  // Offsets are mostly small so that the clamps are hit from both sides, with
  // the extremes of the signed range mixed in.
  function automatic logic [CW-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {1'b1, {(CW-1){1'b0}}};
      2:       return {1'b0, {(CW-1){1'b1}}};
      3:       return CW'($urandom);
      default: return CW'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  // Coordinates mostly fall within the current bound of the axis, which is
  // the screen size for pixel events and the logical max otherwise.
  function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] bound);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return CW'($urandom);
      default: return (bound == '0) ? CW'($urandom) : CW'($urandom_range(0, bound));
    endcase
  endfunction

  initial begin : stimulus
    int            burst_left;
    int            gap;
    int            reports_sent;
    pointer_op_t   op;
    logic          link;
    logic [CW-1:0] sw;
    logic [CW-1:0] sh;
    logic [CW-1:0] mx;
    logic [CW-1:0] my;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_operation  = OP_LOGICAL;
    in_coord_x    = '0;
    in_coord_y    = '0;
    in_tip_switch = 1'b0;
    in_in_range   = 1'b0;
    in_link_up    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_addr      = REG_SCREEN_WIDTH;
    cfg_wdata     = '0;
    run_done      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers at their reset value: every logical max is zero, so sums wrap
    // and pixel mode is off because the screen size is zero.
    send_event(OP_LOGICAL, '0, '0, 1'b0, 1'b0, 1'b1);
    send_event(OP_LOGICAL, '1, '1, 1'b1, 1'b1, 1'b1);
    send_event(OP_PIXEL, 16'd1234, 16'd5678, 1'b1, 1'b0, 1'b1);
    send_event(OP_PIXEL, 16'hAAAA, 16'h5555, 1'b1, 1'b1, 1'b0);

    // A plain full HD screen: corners, coordinates past the edge that are
    // clamped to size minus one, and a logical event above the logical max.
    set_config(16'd1920, 16'd1080, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0);
    send_event(OP_PIXEL, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1);
    send_event(OP_PIXEL, 16'd1919, 16'd1079, 1'b1, 1'b1, 1'b1);
    send_event(OP_PIXEL, '1, '1, 1'b1, 1'b0, 1'b1);
    send_event(OP_PIXEL, 16'd960, 16'd540, 1'b0, 1'b0, 1'b1);
    send_event(OP_LOGICAL, 16'd40000, 16'd100, 1'b1, 1'b1, 1'b1);
    send_event(OP_PIXEL, 16'd10, 16'd10, 1'b1, 1'b1, 1'b0);

    // A width of one leaves x unscaled, a zero max on y leaves y unscaled and
    // wrapping; the offsets sit at the ends of the signed range.
    set_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'h8000, 16'h7FFF);
    send_event(OP_PIXEL, 16'd100, 16'hFFFE, 1'b0, 1'b1, 1'b1);
    send_event(OP_PIXEL, 16'd0, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    send_event(OP_LOGICAL, 16'hFFFF, 16'h8001, 1'b1, 1'b1, 1'b1);

    // Largest width against the smallest useful height, a logical max of one
    // and an offset of minus one that pushes y below zero.
    set_config(16'hFFFF, 16'd2, 16'd1, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    send_event(OP_PIXEL, 16'hFFFF, 16'd0, 1'b1, 1'b1, 1'b1);
    send_event(OP_PIXEL, 16'd1, 16'd1, 1'b0, 1'b1, 1'b1);
    send_event(OP_LOGICAL, 16'd0, 16'hFFFF, 1'b1, 1'b0, 1'b1);

    // A zero height turns pixel scaling off for both axes.
    set_config(16'd640, 16'd0, 16'd1000, 16'd1000, 16'hFFFB, 16'd5);
    send_event(OP_PIXEL, 16'd639, 16'd479, 1'b1, 1'b1, 1'b1);
    send_event(OP_PIXEL, 16'd2000, 16'd0, 1'b0, 1'b0, 1'b1);

    // Random phases, each with a fresh register set. The sender runs in
    // bursts of random length, some back to back, with random gaps between.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      sw = pick_size();
      sh = pick_size();
      mx = pick_size();
      my = pick_size();
      set_config(sw, sh, mx, my, pick_offset(), pick_offset());
      burst_left   = 0;
      reports_sent = 0;
      while (reports_sent < REPORTS_PER_PHASE) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        op   = pointer_op_t'($urandom_range(0, 1));
        link = ($urandom_range(0, 7) != 0);
        send_event(op, pick_coord(op == OP_PIXEL ? sw : mx),
                   pick_coord(op == OP_PIXEL ? sh : my),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), link);
        burst_left--;
        if (link) reports_sent++;
      end
    end

    // Drain, let the checker look for reports that never came, then decide.
    wait_idle();
    @(negedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("** absolute_pointer_report_mapper: PASSED **");
    end else begin
      $display("** absolute_pointer_report_mapper: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/apm_pkg.sv
src/apm_div.sv
src/apm_lane.sv
src/apm_merge.sv
src/absolute_pointer_report_mapper.sv
tb/sv/apm_report_checker.sv
tb/sv/tb_absolute_pointer_report_mapper.sv
